>>> sv/msr_pkg.sv
// msr_pkg: shared widths, types and reset constants for the measurement stream resampler
// no dependencies
package msr_pkg;

  localparam int TIME_W      = 48;
  localparam int VAL_W       = 32;
  localparam int IVL_W       = 20;
  localparam int VALUE_COUNT = 6;

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(50000);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [IVL_W-1:0]  ivl_t;

endpackage

>>> sv/measurement_stream_resampler_core.sv
// measurement_stream_resampler_core: puts timestamped track states on a fixed time grid
// depends on msr_pkg
//
// usage
// - input channel in_valid/in_ready carries one sample: in_sample_time and six Q16.16 values
// - result channel out_valid/out_ready carries one grid point: out_grid_time and six values
// - cfg_valid/cfg_ready writes the grid spacing; cfg_ready is always high, write only when idle
// - the first sample after reset is passed through and becomes the last grid point
// - a later sample more than one interval past the last grid point gives one grid point at
//   last time plus interval, interpolated with one shared fraction; other samples give nothing
// - the fraction comes from a restoring divider, one quotient bit per cycle,
//   then six lanes of shift-add multipliers, one fraction bit per cycle
// - steps for an interpolated point: gap, check, divide, multiply, finish, output; for the
//   first sample: gap, first, output; a sample not ahead in time returns to idle after the gap
//   step, a gap within the interval after the check step
// - one sample at a time: in_ready is high only while idle, so a new sample waits until the
//   last one has left the final step
// - the result sits in an output register; a new sample is taken while it waits, and the
//   next result waits in its final step until the register is free
// - reset clears the interval to 50000, the grid history and the output valid flag
module measurement_stream_resampler_core
  import msr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IVL_W-1:0]        cfg_resample_interval,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIME_W-1:0]       in_sample_time,
  input  logic signed [VAL_W-1:0] in_pos_x,
  input  logic signed [VAL_W-1:0] in_vel_x,
  input  logic signed [VAL_W-1:0] in_pos_y,
  input  logic signed [VAL_W-1:0] in_vel_y,
  input  logic signed [VAL_W-1:0] in_pos_z,
  input  logic signed [VAL_W-1:0] in_vel_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TIME_W-1:0]       out_grid_time,
  output logic signed [VAL_W-1:0] out_grid_pos_x,
  output logic signed [VAL_W-1:0] out_grid_vel_x,
  output logic signed [VAL_W-1:0] out_grid_pos_y,
  output logic signed [VAL_W-1:0] out_grid_vel_y,
  output logic signed [VAL_W-1:0] out_grid_pos_z,
  output logic signed [VAL_W-1:0] out_grid_vel_z
);

  localparam int ACC_W = VAL_W + FRAC_BITS + 2;
  localparam int CNT_W = $clog2(FRAC_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GAP   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_FIRST = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  ivl_t                   ivl_r;
  logic                   have_point_r;
  logic                   out_valid_r;
  time_t                  last_time_r;
  val_t                   last_vals_r [VALUE_COUNT];
  time_t                  smp_time_r;
  val_t                   smp_vals_r [VALUE_COUNT];
  val_t                   in_vals [VALUE_COUNT];
  time_t                  gap_r;
  time_t                  rem_r;
  logic [FRAC_BITS-1:0]   frac_r;
  logic signed [VAL_W:0]  diff_r [VALUE_COUNT];
  logic signed [ACC_W-1:0] acc_r [VALUE_COUNT];
  time_t                  out_time_r;
  val_t                   out_vals_r [VALUE_COUNT];

  logic [TIME_W:0]        gap_wide;
  logic [TIME_W:0]        rem_dbl;
  logic                   rem_geq;
  logic [TIME_W:0]        rem_sub;
  logic                   cnt_last;
  logic                   out_free;
  logic                   in_xfer;

  assign in_vals[0] = in_pos_x;
  assign in_vals[1] = in_vel_x;
  assign in_vals[2] = in_pos_y;
  assign in_vals[3] = in_vel_y;
  assign in_vals[4] = in_pos_z;
  assign in_vals[5] = in_vel_z;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_last  = (cnt_r == CNT_W'(FRAC_BITS - 1));

  assign gap_wide = {1'b0, smp_time_r} - {1'b0, last_time_r};
  assign rem_dbl  = {rem_r, 1'b0};
  assign rem_geq  = (rem_dbl >= {1'b0, gap_r});
  assign rem_sub  = rem_dbl - {1'b0, gap_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        if (!have_point_r) begin
          state_nxt = S_FIRST;
        end else if (gap_wide[TIME_W] || (gap_wide == '0)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (gap_r > TIME_W'(ivl_r)) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_OUT;
      S_FIRST: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      ivl_r        <= IVL_RESET;
      have_point_r <= 1'b0;
      out_valid_r  <= 1'b0;
      last_time_r  <= '0;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        last_vals_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        ivl_r <= cfg_resample_interval;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_FIRST: begin
          have_point_r <= 1'b1;
          last_time_r  <= smp_time_r;
          for (int i = 0; i < VALUE_COUNT; i++) begin
            last_vals_r[i] <= smp_vals_r[i];
          end
        end
        S_FIN: begin
          last_time_r <= last_time_r + TIME_W'(ivl_r);
          for (int i = 0; i < VALUE_COUNT; i++) begin
            last_vals_r[i] <= last_vals_r[i]
                + val_t'((acc_r[i] + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: sample capture, serial divider, serial multiplier lanes, output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp_time_r <= in_sample_time;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        smp_vals_r[i] <= in_vals[i];
      end
    end
    case (state_r)
      S_GAP: gap_r <= gap_wide[TIME_W-1:0];
      S_CHK: begin
        rem_r <= TIME_W'(ivl_r);
        for (int i = 0; i < VALUE_COUNT; i++) begin
          diff_r[i] <= {smp_vals_r[i][VAL_W-1], smp_vals_r[i]}
                     - {last_vals_r[i][VAL_W-1], last_vals_r[i]};
          acc_r[i]  <= '0;
        end
      end
      S_DIV: begin
        rem_r  <= rem_geq ? rem_sub[TIME_W-1:0] : rem_dbl[TIME_W-1:0];
        frac_r <= {frac_r[FRAC_BITS-2:0], rem_geq};
      end
      S_MUL: begin
        frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
        for (int i = 0; i < VALUE_COUNT; i++) begin
          acc_r[i] <= (acc_r[i] <<< 1)
              + (frac_r[FRAC_BITS-1] ? ACC_W'(diff_r[i]) : ACC_W'(0));
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_time_r <= last_time_r;
          for (int i = 0; i < VALUE_COUNT; i++) begin
            out_vals_r[i] <= last_vals_r[i];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_grid_time  = out_time_r;
  assign out_grid_pos_x = out_vals_r[0];
  assign out_grid_vel_x = out_vals_r[1];
  assign out_grid_pos_y = out_vals_r[2];
  assign out_grid_vel_y = out_vals_r[3];
  assign out_grid_pos_z = out_vals_r[4];
  assign out_grid_vel_z = out_vals_r[5];

  // divider remainder stays below the gap
  a_rem_below_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < gap_r))
    else $error("divider remainder not below gap");

  // a grid point is only ever loaded from the final step
  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("output loaded outside final step");

  // once a grid point exists it is never forgotten
  a_have_point_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_point_r |=> have_point_r)
    else $error("grid history lost");

  // interpolation only runs with a grid point in hand
  a_interp_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) || (state_r == S_MUL) || (state_r == S_FIN)) |-> have_point_r)
    else $error("interpolation without grid point");

endmodule
